FILE: rtl/tcr_pkg.sv
`default_nettype none

package tcr_pkg;

    typedef enum logic [1:0] {
        CMD_PUT  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_GLYPH,
        S_MOVE,
        S_SCROLL_PRE,
        S_SCROLL,
        S_FLIP0,
        S_FLIP1,
        S_FLIP2,
        S_READ,
        S_DONE
    } t_state;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_END   = 8'd127;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;

    localparam int GLYPH_ROWS = 760;
    localparam int GLYPH_AW   = 10;
    localparam int BAR_ROW    = 6;
    localparam int BLINK_W    = 4;

endpackage

`default_nettype wire

FILE: rtl/text_console_renderer_core.sv
// Path from accepted start to o_valid, ending in S_DONE: load via S_DECODE, read via S_READ, tick
// via S_FLIP0-2 when the bar flips, put via S_GLYPH/S_MOVE, plus S_SCROLL when a line feed scrolls.
// Throughput: one transaction at a time; start is taken again in the o_valid cycle.
// Cost is set by the single-port-per-direction frame store: one byte read and one written per cycle.
// Reset: synchronous active-low; busy stays high while the frame store is cleared.
// Results are shown for one cycle; the receiver cannot stall.
`default_nettype none

module text_console_renderer_core #(
    parameter int TEXT_COLS = 32,
    parameter int TEXT_ROWS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [12:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic [4:0]  o_cursor_row_now,
    output logic [4:0]  o_cursor_col_now,
    output logic        o_cursor_visible
);

    import tcr_pkg::*;

    localparam int FRAME_BYTES = TEXT_COLS * TEXT_ROWS * 8;
    localparam int ROW_BYTES   = TEXT_COLS * 8;
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int CW          = $clog2(TEXT_COLS);
    localparam int RW          = $clog2(TEXT_ROWS);
    localparam int ACW         = ((FA_W > 13) ? FA_W : 13) + 1;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [7:0]          r_code, n_code;
    logic [12:0]         r_addr_in, n_addr_in;
    logic [7:0]          r_data, n_data;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic                r_drawn, n_drawn;
    logic [BLINK_W-1:0]  r_blink, n_blink;
    logic [FA_W-1:0]     r_cnt, n_cnt;
    logic [3:0]          r_gi, n_gi;
    logic [FA_W-1:0]     r_waddr, n_waddr;
    logic                r_post, n_post;
    logic [7:0]          r_rd, n_rd;
    logic                r_valid, n_valid;
    logic [7:0]          r_out_rd, n_out_rd;
    logic [4:0]          r_out_row, n_out_row;
    logic [4:0]          r_out_col, n_out_col;
    logic                r_out_vis, n_out_vis;

    logic                fr_we;
    logic [FA_W-1:0]     fr_waddr;
    logic [7:0]          fr_wdata;
    logic [FA_W-1:0]     fr_raddr;
    logic [7:0]          fr_rdata;
    logic                gl_we;
    logic [GLYPH_AW-1:0] gl_waddr;
    logic [GLYPH_AW-1:0] gl_raddr;
    logic [7:0]          gl_rdata;

    logic [FA_W-1:0]     cell_base;
    logic [FA_W-1:0]     bar_addr;
    logic [FA_W-1:0]     bar_next;
    logic                printable;
    logic                is_lf;
    logic                is_cr;
    logic                col_last;
    logic                row_last;
    logic                line_feed;
    logic                frame_hit;
    logic                glyph_hit;
    logic [FA_W:0]       scroll_next;
    logic                cnt_last;

    tcr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    tcr_ram #(.WIDTH(8), .DEPTH(GLYPH_ROWS)) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (gl_we),
        .i_waddr (gl_waddr),
        .i_wdata (r_data),
        .i_raddr (gl_raddr),
        .o_rdata (gl_rdata)
    );

    assign cell_base   = FA_W'(r_col) + FA_W'(FA_W'(r_row) * FA_W'(ROW_BYTES));
    assign bar_addr    = cell_base + FA_W'(BAR_ROW * TEXT_COLS);
    assign bar_next    = bar_addr + FA_W'(TEXT_COLS);
    assign printable   = (r_code >= CHAR_FIRST) && (r_code < CHAR_END);
    assign is_lf       = (r_code == CHAR_LF);
    assign is_cr       = (r_code == CHAR_CR);
    assign col_last    = (r_col == CW'(TEXT_COLS - 1));
    assign row_last    = (r_row == RW'(TEXT_ROWS - 1));
    assign line_feed   = (printable && col_last) || is_lf;
    assign frame_hit   = ACW'(r_addr_in) < ACW'(FRAME_BYTES);
    assign glyph_hit   = r_addr_in < 13'(GLYPH_ROWS);
    assign scroll_next = (FA_W + 1)'(r_cnt) + (FA_W + 1)'(ROW_BYTES + 1);
    assign cnt_last    = (r_cnt == FA_W'(FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_col   <= '0;
            r_drawn <= 1'b0;
            r_blink <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_gi    <= '0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_drawn <= n_drawn;
            r_blink <= n_blink;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_gi    <= n_gi;
            r_post  <= n_post;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_code    <= n_code;
        r_addr_in <= n_addr_in;
        r_data    <= n_data;
        r_waddr   <= n_waddr;
        r_rd      <= n_rd;
        r_out_rd  <= n_out_rd;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_out_vis <= n_out_vis;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_code    = r_code;
        n_addr_in = r_addr_in;
        n_data    = r_data;
        n_row     = r_row;
        n_col     = r_col;
        n_drawn   = r_drawn;
        n_blink   = r_blink;
        n_cnt     = r_cnt;
        n_gi      = r_gi;
        n_waddr   = r_waddr;
        n_post    = r_post;
        n_rd      = r_rd;
        n_valid   = 1'b0;
        n_out_rd  = r_out_rd;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_out_vis = r_out_vis;
        fr_we     = 1'b0;
        fr_waddr  = r_cnt;
        fr_wdata  = '0;
        fr_raddr  = '0;
        gl_we     = 1'b0;
        gl_waddr  = GLYPH_AW'(r_addr_in);
        gl_raddr  = '0;

        unique case (r_state)
            S_CLEAR: begin
                fr_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd     = t_cmd'(i_command);
                    n_code    = i_char_code;
                    n_addr_in = i_address;
                    n_data    = i_data;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rd = '0;
                unique case (r_cmd)
                    CMD_PUT: begin
                        if (printable) begin
                            n_waddr = cell_base;
                            n_gi    = '0;
                            n_state = S_GLYPH;
                        end else if (is_lf || is_cr) begin
                            n_post  = 1'b0;
                            n_state = r_drawn ? S_FLIP0 : S_MOVE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_TICK: begin
                        n_blink = r_blink + 1'b1;
                        if (r_blink == '0) begin
                            n_drawn = !r_drawn;
                            n_post  = 1'b1;
                            n_state = S_FLIP0;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_LOAD: begin
                        gl_we   = glyph_hit;
                        n_state = S_DONE;
                    end
                    CMD_READ: begin
                        fr_raddr = FA_W'(r_addr_in);
                        n_state  = S_READ;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_GLYPH: begin
                gl_raddr = {7'(r_code - CHAR_FIRST), r_gi[2:0]};
                n_gi     = r_gi + 1'b1;
                if (r_gi != '0) begin
                    fr_we    = 1'b1;
                    fr_waddr = r_waddr;
                    fr_wdata = gl_rdata;
                    n_waddr  = r_waddr + FA_W'(TEXT_COLS);
                end
                if (r_gi == 4'd8) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (printable) begin
                    n_col = col_last ? '0 : r_col + 1'b1;
                end else if (is_cr) begin
                    n_col = '0;
                end
                n_post = 1'b1;
                if (line_feed && row_last) begin
                    n_state = S_SCROLL_PRE;
                end else begin
                    if (line_feed) begin
                        n_row = r_row + 1'b1;
                    end
                    n_state = r_drawn ? S_FLIP0 : S_DONE;
                end
            end
            S_SCROLL_PRE: begin
                fr_raddr = FA_W'(ROW_BYTES);
                n_cnt    = '0;
                n_state  = S_SCROLL;
            end
            S_SCROLL: begin
                fr_we    = 1'b1;
                fr_waddr = r_cnt;
                fr_wdata = (r_cnt < FA_W'(FRAME_BYTES - ROW_BYTES)) ? fr_rdata : '0;
                if (scroll_next < (FA_W + 1)'(FRAME_BYTES)) begin
                    fr_raddr = FA_W'(scroll_next);
                end
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = r_drawn ? S_FLIP0 : S_DONE;
                end
            end
            S_FLIP0: begin
                fr_raddr = bar_addr;
                n_state  = S_FLIP1;
            end
            S_FLIP1: begin
                fr_we    = 1'b1;
                fr_waddr = bar_addr;
                fr_wdata = fr_rdata ^ BYTE_ONES;
                fr_raddr = bar_next;
                n_state  = S_FLIP2;
            end
            S_FLIP2: begin
                fr_we    = 1'b1;
                fr_waddr = bar_next;
                fr_wdata = fr_rdata ^ BYTE_ONES;
                n_state  = r_post ? S_DONE : S_MOVE;
            end
            S_READ: begin
                n_rd    = frame_hit ? fr_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid   = 1'b1;
                n_out_rd  = r_rd;
                n_out_row = 5'(r_row);
                n_out_col = 5'(r_col);
                n_out_vis = r_drawn;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_read_data      = r_out_rd;
    assign o_cursor_row_now = r_out_row;
    assign o_cursor_col_now = r_out_col;
    assign o_cursor_visible = r_out_vis;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result strobe right after accepting a transaction");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < CW'(TEXT_COLS - 1)) || (r_col == CW'(TEXT_COLS - 1)))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < RW'(TEXT_ROWS - 1)) || (r_row == RW'(TEXT_ROWS - 1)))
        else $error("cursor row out of range");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!fr_we && !gl_we))
        else $error("store write while idle");

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && fr_raddr != '0) |-> (fr_raddr > fr_waddr))
        else $error("scroll read behind write");

endmodule

`default_nettype wire

FILE: rtl/tcr_ram.sv
`default_nettype none

module tcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tcr_pkg::*;

    localparam int COLS           = 32;
    localparam int ROWS           = 24;
    localparam int ROW_BYTES      = COLS * 8;
    localparam int FB_BYTES       = COLS * ROWS * 8;
    localparam int ADDR_TOP       = 8191;
    localparam int SCROLL_BUDGET  = 60;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [7:0] rd;
        logic [4:0] row;
        logic [4:0] col;
        logic       vis;
    } console_out_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_command;
    logic [7:0]  i_char_code;
    logic [12:0] i_address;
    logic [7:0]  i_data;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [4:0]  o_cursor_row_now;
    logic [4:0]  o_cursor_col_now;
    logic        o_cursor_visible;

    logic [7:0]            fb_model [FB_BYTES];
    logic [7:0]            font_model [GLYPH_ROWS];
    bit [GLYPH_ROWS-1:0]   font_set;
    bit [127:0]            glyph_ready;
    int unsigned           ready_codes [$];
    int unsigned           cur_row;
    int unsigned           cur_col;
    bit                    bar_on;
    logic [3:0]            blink;
    int unsigned           scroll_count;

    console_out_t          pending_views [$];
    int unsigned           mismatch_count;
    int unsigned           sent_items;
    int unsigned           send_idle_pct;
    int unsigned           quiet_cycles;
    int unsigned           view_index;

    text_console_renderer_core #(
        .TEXT_COLS(COLS),
        .TEXT_ROWS(ROWS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_address       (i_address),
        .i_data          (i_data),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_cursor_row_now(o_cursor_row_now),
        .o_cursor_col_now(o_cursor_col_now),
        .o_cursor_visible(o_cursor_visible)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void toggle_bar();
        int unsigned at;
        at = cur_col + (cur_row * 8 + BAR_ROW) * COLS;
        if (at + COLS < FB_BYTES) begin
            fb_model[at]        = fb_model[at] ^ BYTE_ONES;
            fb_model[at + COLS] = fb_model[at + COLS] ^ BYTE_ONES;
        end
    endfunction

    function automatic void advance_line();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < FB_BYTES - ROW_BYTES; i++) fb_model[i] = fb_model[i + ROW_BYTES];
            for (int i = FB_BYTES - ROW_BYTES; i < FB_BYTES; i++) fb_model[i] = '0;
            cur_row = ROWS - 1;
            scroll_count++;
        end
    endfunction

    function automatic bit is_printable(logic [7:0] code);
        return code >= CHAR_FIRST && code < CHAR_END;
    endfunction

    function automatic void draw_put(logic [7:0] code);
        bit          shown;
        int unsigned g;
        int unsigned at;
        int unsigned d;
        shown = bar_on;
        if (shown) toggle_bar();
        if (is_printable(code)) begin
            g  = (code - CHAR_FIRST) * 8;
            at = cur_col + cur_row * ROW_BYTES;
            for (int i = 0; i < 8; i++) begin
                d = at + i * COLS;
                if (d < FB_BYTES && g + i < GLYPH_ROWS) fb_model[d] = font_model[g + i];
            end
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                advance_line();
            end
        end else if (code == CHAR_LF) begin
            advance_line();
        end else if (code == CHAR_CR) begin
            cur_col = 0;
        end
        if (shown) toggle_bar();
    endfunction

    function automatic console_out_t console_step(t_cmd cmd, logic [7:0] code,
                                                  logic [12:0] addr, logic [7:0] dat);
        console_out_t v;
        int unsigned  base;
        int unsigned  c;
        v.rd = '0;
        case (cmd)
            CMD_PUT: draw_put(code);
            CMD_TICK: begin
                if (blink == 4'd0) begin
                    toggle_bar();
                    bar_on = !bar_on;
                end
                blink = blink + 4'd1;
            end
            CMD_LOAD: begin
                if (addr < GLYPH_ROWS) begin
                    font_model[addr] = dat;
                    font_set[addr]   = 1'b1;
                    base = (addr / 8) * 8;
                    c    = addr / 8 + CHAR_FIRST;
                    if (font_set[base +: 8] == 8'hFF && !glyph_ready[c]) begin
                        glyph_ready[c] = 1'b1;
                        ready_codes.push_back(c);
                    end
                end
            end
            default: begin
                if (addr < FB_BYTES) v.rd = fb_model[addr];
            end
        endcase
        v.row = 5'(cur_row);
        v.col = 5'(cur_col);
        v.vis = bar_on;
        return v;
    endfunction

    function automatic logic [7:0] pick_ready();
        return 8'(ready_codes[$urandom_range(ready_codes.size() - 1)]);
    endfunction

    task automatic send_txn(input t_cmd cmd, input logic [7:0] code,
                            input logic [12:0] addr, input logic [7:0] dat);
        bit ignored;
        ignored = (cmd == CMD_PUT && !is_printable(code) && code != CHAR_LF
                   && code != CHAR_CR) || (cmd == CMD_LOAD && addr >= GLYPH_ROWS);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_char_code <= code;
        i_address   <= addr;
        i_data      <= dat;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_views.push_back(console_step(cmd, code, addr, dat));
        if (!ignored) sent_items++;
    endtask

    task automatic send_put(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        // hold the scroll count down so the run stays short
        if (scroll_count >= SCROLL_BUDGET && cur_row == ROWS - 1 &&
            (c == CHAR_LF || (is_printable(c) && cur_col == COLS - 1)))
            c = CHAR_CR;
        send_txn(CMD_PUT, c, 13'($urandom), 8'($urandom));
    endtask

    task automatic send_tick();
        send_txn(CMD_TICK, 8'($urandom), 13'($urandom), 8'($urandom));
    endtask

    task automatic send_read(input logic [12:0] addr);
        send_txn(CMD_READ, 8'($urandom), addr, 8'($urandom));
    endtask

    task automatic send_random_read();
        int unsigned pick;
        logic [12:0] a;
        pick = $urandom_range(99);
        if (pick < 50)
            a = 13'((cur_row * 8 + $urandom_range(7)) * COLS + $urandom_range(COLS - 1));
        else if (pick < 85)
            a = 13'($urandom_range(FB_BYTES - 1));
        else
            a = 13'($urandom_range(ADDR_TOP, FB_BYTES));
        send_read(a);
    endtask

    task automatic load_glyph(input int unsigned code);
        logic [7:0] d;
        for (int r = 0; r < 8; r++) begin
            if ($urandom_range(9) == 0) d = $urandom_range(1) ? 8'hFF : 8'h00;
            else d = 8'($urandom);
            send_txn(CMD_LOAD, 8'($urandom), 13'((code - CHAR_FIRST) * 8 + r), d);
        end
    endtask

    task automatic drain_views(input int unsigned settle);
        start <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_cleared_store();
        send_read(13'd0);
        send_read(13'(FB_BYTES - 1));
        send_read(13'(ADDR_TOP));
    endtask

    task automatic test_glyph_load();
        send_txn(CMD_LOAD, 8'hFF, 13'(GLYPH_ROWS), 8'hFF);
        send_txn(CMD_LOAD, 8'h00, 13'(ADDR_TOP), 8'h00);
        load_glyph(126);
    endtask

    task automatic test_cursor_and_codes();
        send_tick();
        send_put(8'd126);
        send_read(13'(7 * COLS));
        send_read(13'(BAR_ROW * COLS + 1));
        send_put(8'd0);
        send_put(8'd255);
        send_put(8'd31);
        send_put(CHAR_END);
        send_put(CHAR_CR);
        send_put(CHAR_LF);
        send_read(13'(BAR_ROW * COLS + ROW_BYTES));
    endtask

    task automatic test_text_stream(input int unsigned n_items, input int unsigned idle_pct);
        int unsigned goal;
        int unsigned kind;
        int unsigned n;
        int unsigned c;
        logic [7:0]  code;
        goal = sent_items + n_items;
        send_idle_pct = idle_pct;
        while (sent_items < goal) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                n = ($urandom_range(7) == 0) ? COLS - cur_col : $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(99) < 10) begin
                        if ($urandom_range(1)) send_tick();
                        else send_random_read();
                    end
                    send_put(pick_ready());
                end
                kind = $urandom_range(99);
                if (kind < 50) begin
                    send_put(CHAR_CR);
                    send_put(CHAR_LF);
                end else if (kind < 70) begin
                    send_put(CHAR_LF);
                end else if (kind < 85) begin
                    send_put(CHAR_CR);
                end
            end else if (kind < 55) begin
                c = $urandom_range(126, 32);
                if ($urandom_range(9) < 7) begin
                    for (int k = 0; k < 95 && glyph_ready[c]; k++) c = (c == 126) ? 32 : c + 1;
                end
                load_glyph(c);
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 20)) send_tick();
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 8)) send_random_read();
            end else begin
                case ($urandom_range(3))
                    0: begin
                        code = 8'($urandom_range(255));
                        if (is_printable(code) && !glyph_ready[code]) code = pick_ready();
                        send_put(code);
                    end
                    1: send_tick();
                    2: send_txn(CMD_LOAD, 8'($urandom), 13'($urandom_range(ADDR_TOP)),
                                8'($urandom));
                    default: send_random_read();
                endcase
            end
        end
        drain_views(0);
    endtask

    always @(posedge i_clk) begin
        console_out_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            view_index++;
            if (pending_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("transaction %0d: result with no pending request", view_index);
            end else begin
                want = pending_views.pop_front();
                if ({o_read_data, o_cursor_row_now, o_cursor_col_now, o_cursor_visible}
                    !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("transaction %0d: expected rd=%h row=%0d col=%0d vis=%b, ",
                               view_index, want.rd, want.row, want.col, want.vis);
                        $display("got rd=%h row=%0d col=%0d vis=%b", o_read_data,
                                 o_cursor_row_now, o_cursor_col_now, o_cursor_visible);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < FB_BYTES; i++) fb_model[i] = '0;
        for (int i = 0; i < GLYPH_ROWS; i++) font_model[i] = '0;
        font_set       = '0;
        glyph_ready    = '0;
        cur_row        = 0;
        cur_col        = 0;
        bar_on         = 1'b0;
        blink          = '0;
        scroll_count   = 0;
        mismatch_count = 0;
        sent_items     = 0;
        send_idle_pct  = 0;
        quiet_cycles   = 0;
        view_index     = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_TICK;
        i_char_code <= '0;
        i_address   <= '0;
        i_data      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_store();
        test_glyph_load();
        test_cursor_and_codes();
        drain_views(0);
        test_text_stream(600, 20);
        test_text_stream(600, 51);
        test_text_stream(600, 0);
        drain_views(SETTLE_CYCLES);

        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
